[hw/rtl/rms_pkg.sv]
// Shared constants and a helper function for the regret-matching sampler.
`timescale 1ns / 1ps

package rms_pkg;

    // Number of action fields carried by one item
    localparam int FIELDS = 7;

    // Default sizing of the block
    localparam int NUM_ACTIONS_DEF = 7;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int REGRET_BITS_DEF = 32;

    // Width of the allowed-action count
    localparam int CNT_W = 4;

    // Widest uniform probability word (FRAC_BITS at most 24, plus one)
    localparam int UNI_W = 25;

    // Reported when no action is selected
    localparam logic [2:0] NO_ACTION = 3'd7;

    // floor(2^fb / cnt) for the uniform fallback; cnt of zero gives zero
    function automatic logic [UNI_W-1:0] uni_prob(input logic [CNT_W-1:0] cnt, input int fb);
        logic [UNI_W-1:0] one;
        logic [UNI_W-1:0] res;
        one = UNI_W'(1) << fb;
        case (cnt)
            4'd1:    res = one;
            4'd2:    res = one >> 1;
            4'd3:    res = one / 3;
            4'd4:    res = one >> 2;
            4'd5:    res = one / 5;
            4'd6:    res = one / 6;
            4'd7:    res = one / 7;
            4'd8:    res = one >> 3;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[hw/rtl/rms_lane.sv]
// One divider lane: pipelined restoring division, one quotient bit per stage.
`timescale 1ns / 1ps

module rms_lane #(
    parameter int SUM_W = rms_pkg::REGRET_BITS_DEF + 2,
    parameter int QB    = rms_pkg::FRAC_BITS_DEF + 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [SUM_W-1:0] num,
    input  logic [SUM_W-1:0] den,
    output logic [QB-1:0]    quo
);

    logic [SUM_W-1:0] rem_reg [QB];
    logic [SUM_W-1:0] den_reg [QB];
    logic [QB-1:0]    q_reg   [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic [SUM_W:0]   in_rem;
            logic [SUM_W-1:0] in_den;
            logic [QB-1:0]    in_q;
            logic             ge;
            logic [SUM_W:0]   diff;

            // First stage takes the numerator, later ones the shifted remainder
            if (k == 0) begin : g_first
                assign in_rem = {1'b0, num};
                assign in_den = den;
                assign in_q   = '0;
            end else begin : g_next
                assign in_rem = {rem_reg[k-1], 1'b0};
                assign in_den = den_reg[k-1];
                assign in_q   = q_reg[k-1];
            end

            assign ge   = in_rem >= {1'b0, in_den};
            assign diff = in_rem - {1'b0, in_den};

            // Payload only, no reset
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[SUM_W-1:0] : in_rem[SUM_W-1:0];
                    den_reg[k] <= in_den;
                    q_reg[k]   <= {in_q[QB-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = q_reg[QB-1];

endmodule

[hw/rtl/rms_merge.sv]
// Merge stage: picks lane quotients or the uniform share, then samples an action.
`timescale 1ns / 1ps

module rms_merge #(
    parameter int PW = rms_pkg::FRAC_BITS_DEF + 1
) (
    input  logic [rms_pkg::FIELDS-1:0] mask,
    input  logic                       zero_sum,
    input  logic [PW-1:0]              uni,
    input  logic [PW-1:0]              quo  [rms_pkg::FIELDS],
    input  logic [PW-2:0]              rnd,
    output logic [PW-1:0]              prob [rms_pkg::FIELDS],
    output logic [2:0]                 chosen
);

    localparam int ACC_W = PW + 3;

    logic [ACC_W-1:0] acc;
    logic             found;

    // Running sum, first allowed action reaching the fraction wins
    always_comb
    begin
        acc    = '0;
        found  = 1'b0;
        chosen = rms_pkg::NO_ACTION;
        for (int a = 0; a < rms_pkg::FIELDS; a++)
        begin
            prob[a] = mask[a] ? (zero_sum ? uni : quo[a]) : '0;
            acc     = acc + ACC_W'(prob[a]);
            if (mask[a] && !found && (ACC_W'(rnd) <= acc))
            begin
                found  = 1'b1;
                chosen = 3'(a);
            end
        end
    end

endmodule

[hw/rtl/regret_matching_sampler.sv]
// Regret-matching sampler top level: one item per cycle through parallel divider lanes
// while no result is held. Stages: clip, sum, FRAC_BITS + 1 divider stages, merge and
// output register; each action has its own restoring-divider lane that produces one
// quotient bit per stage. The whole pipeline holds while a result waits under
// out_stall, which in_stall then reflects.
`timescale 1ns / 1ps

module regret_matching_sampler #(
    parameter int NUM_ACTIONS = rms_pkg::NUM_ACTIONS_DEF,
    parameter int FRAC_BITS   = rms_pkg::FRAC_BITS_DEF,
    parameter int REGRET_BITS = rms_pkg::REGRET_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [6:0]             allowed_mask,
    input  logic [REGRET_BITS-1:0] regret_fold,
    input  logic [REGRET_BITS-1:0] regret_call,
    input  logic [REGRET_BITS-1:0] regret_check,
    input  logic [REGRET_BITS-1:0] regret_bet_quarter,
    input  logic [REGRET_BITS-1:0] regret_bet_half,
    input  logic [REGRET_BITS-1:0] regret_bet_pot,
    input  logic [REGRET_BITS-1:0] regret_bet_over,
    input  logic [FRAC_BITS-1:0]   random_fraction,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FRAC_BITS:0]     prob_fold,
    output logic [FRAC_BITS:0]     prob_call,
    output logic [FRAC_BITS:0]     prob_check,
    output logic [FRAC_BITS:0]     prob_bet_quarter,
    output logic [FRAC_BITS:0]     prob_bet_half,
    output logic [FRAC_BITS:0]     prob_bet_pot,
    output logic [FRAC_BITS:0]     prob_bet_over,
    output logic [2:0]             chosen_action
);

    localparam int F     = rms_pkg::FIELDS;
    localparam int LANES = (NUM_ACTIONS < F) ? NUM_ACTIONS : F;
    localparam int CW    = REGRET_BITS - 1;
    localparam int SUM_W = REGRET_BITS + 2;
    localparam int PW    = FRAC_BITS + 1;
    localparam int QB    = PW;

    logic en;
    logic out_valid_reg;
    logic [REGRET_BITS-1:0] regret_in [F];

    assign regret_in[0] = regret_fold;
    assign regret_in[1] = regret_call;
    assign regret_in[2] = regret_check;
    assign regret_in[3] = regret_bet_quarter;
    assign regret_in[4] = regret_bet_half;
    assign regret_in[5] = regret_bet_pot;
    assign regret_in[6] = regret_bet_over;

    // Pipeline moves unless a finished result is held back
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Clip stage
    logic          a_valid_reg;
    logic [CW-1:0] a_clip_reg [F];
    logic [F-1:0]  a_mask_reg;
    logic [FRAC_BITS-1:0] a_rnd_reg;
    logic [CW-1:0] clip_next [F];
    logic [F-1:0]  mask_next;

    always_comb
    begin
        for (int a = 0; a < F; a++)
        begin
            mask_next[a] = (a < LANES) && allowed_mask[a];
            clip_next[a] = (mask_next[a] && !regret_in[a][REGRET_BITS-1])
                         ? regret_in[a][CW-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_clip_reg <= clip_next;
            a_mask_reg <= mask_next;
            a_rnd_reg  <= random_fraction;
        end
    end

    // Sum stage
    logic             b_valid_reg;
    logic [SUM_W-1:0] b_num_reg [F];
    logic [SUM_W-1:0] b_sum_reg;
    logic [rms_pkg::CNT_W-1:0] b_cnt_reg;
    logic [F-1:0]     b_mask_reg;
    logic [FRAC_BITS-1:0] b_rnd_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int a = 0; a < F; a++)
            sum_next = sum_next + SUM_W'(a_clip_reg[a]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < F; a++)
                b_num_reg[a] <= SUM_W'(a_clip_reg[a]);
            b_sum_reg  <= sum_next;
            b_cnt_reg  <= rms_pkg::CNT_W'($countones(a_mask_reg));
            b_mask_reg <= a_mask_reg;
            b_rnd_reg  <= a_rnd_reg;
        end
    end

    // Side data travelling alongside the divider lanes
    logic                 s_valid_reg [QB];
    logic [F-1:0]         s_mask_reg  [QB];
    logic [FRAC_BITS-1:0] s_rnd_reg   [QB];
    logic                 s_zero_reg  [QB];
    logic [PW-1:0]        s_uni_reg   [QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QB; k++)
                s_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            s_valid_reg[0] <= b_valid_reg;
            for (int k = 1; k < QB; k++)
                s_valid_reg[k] <= s_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_mask_reg[0] <= b_mask_reg;
            s_rnd_reg[0]  <= b_rnd_reg;
            s_zero_reg[0] <= (b_sum_reg == '0);
            s_uni_reg[0]  <= PW'(rms_pkg::uni_prob(b_cnt_reg, FRAC_BITS));
            for (int k = 1; k < QB; k++)
            begin
                s_mask_reg[k] <= s_mask_reg[k-1];
                s_rnd_reg[k]  <= s_rnd_reg[k-1];
                s_zero_reg[k] <= s_zero_reg[k-1];
                s_uni_reg[k]  <= s_uni_reg[k-1];
            end
        end
    end

    // Divider lanes
    logic [PW-1:0] quo [F];

    genvar g;
    generate
        for (g = 0; g < F; g++) begin : g_lane
            if (g < LANES) begin : g_on
                rms_lane #(
                    .SUM_W (SUM_W),
                    .QB    (QB)
                ) u_lane (
                    .clk (clk),
                    .en  (en),
                    .num (b_num_reg[g]),
                    .den (b_sum_reg),
                    .quo (quo[g])
                );
            end else begin : g_off
                assign quo[g] = '0;
            end
        end
    endgenerate

    // Merge and output register
    logic [PW-1:0] prob_m [F];
    logic [2:0]    chosen_m;
    logic [PW-1:0] prob_reg [F];
    logic [2:0]    chosen_reg;

    rms_merge #(
        .PW (PW)
    ) u_merge (
        .mask     (s_mask_reg[QB-1]),
        .zero_sum (s_zero_reg[QB-1]),
        .uni      (s_uni_reg[QB-1]),
        .quo      (quo),
        .rnd      (s_rnd_reg[QB-1]),
        .prob     (prob_m),
        .chosen   (chosen_m)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s_valid_reg[QB-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prob_reg   <= prob_m;
            chosen_reg <= chosen_m;
        end
    end

    assign out_valid        = out_valid_reg;
    assign prob_fold        = prob_reg[0];
    assign prob_call        = prob_reg[1];
    assign prob_check       = prob_reg[2];
    assign prob_bet_quarter = prob_reg[3];
    assign prob_bet_half    = prob_reg[4];
    assign prob_bet_pot     = prob_reg[5];
    assign prob_bet_over    = prob_reg[6];
    assign chosen_action    = chosen_reg;

endmodule

[hw/rtl/rms_checker.sv]
// Port-level checks for the regret-matching sampler, bound to the top level.
`timescale 1ns / 1ps

module rms_checker #(
    parameter int FRAC_BITS = rms_pkg::FRAC_BITS_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [FRAC_BITS:0] prob_fold,
    input logic [FRAC_BITS:0] prob_call,
    input logic [FRAC_BITS:0] prob_check,
    input logic [FRAC_BITS:0] prob_bet_quarter,
    input logic [FRAC_BITS:0] prob_bet_half,
    input logic [FRAC_BITS:0] prob_bet_pot,
    input logic [FRAC_BITS:0] prob_bet_over,
    input logic [2:0]         chosen_action
);

    localparam int SW = FRAC_BITS + 4;

    logic [SW-1:0] prob_sum;

    assign prob_sum = SW'(prob_fold) + SW'(prob_call) + SW'(prob_check)
                    + SW'(prob_bet_quarter) + SW'(prob_bet_half)
                    + SW'(prob_bet_pot) + SW'(prob_bet_over);

    // A held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chosen_action))
        else $error("result changed while stalled");

    // Input back-pressure only comes from a waiting result
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // Truncated probabilities never add up to more than one
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> prob_sum <= (SW'(1) << FRAC_BITS))
        else $error("probabilities exceed one");

endmodule

bind regret_matching_sampler rms_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_rms_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .prob_fold        (prob_fold),
    .prob_call        (prob_call),
    .prob_check       (prob_check),
    .prob_bet_quarter (prob_bet_quarter),
    .prob_bet_half    (prob_bet_half),
    .prob_bet_pot     (prob_bet_pot),
    .prob_bet_over    (prob_bet_over),
    .chosen_action    (chosen_action)
);

[tb/sv/regret_matching_sampler_checker.sv]
// Checker for the regret-matching sampler: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module regret_matching_sampler_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [6:0]  allowed_mask,
    input  logic [31:0] regret_fold,
    input  logic [31:0] regret_call,
    input  logic [31:0] regret_check,
    input  logic [31:0] regret_bet_quarter,
    input  logic [31:0] regret_bet_half,
    input  logic [31:0] regret_bet_pot,
    input  logic [31:0] regret_bet_over,
    input  logic [15:0] random_fraction,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [16:0] prob_fold,
    input  logic [16:0] prob_call,
    input  logic [16:0] prob_check,
    input  logic [16:0] prob_bet_quarter,
    input  logic [16:0] prob_bet_half,
    input  logic [16:0] prob_bet_pot,
    input  logic [16:0] prob_bet_over,
    input  logic [2:0]  chosen_action,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic [6:0][16:0] prob;
        logic [2:0]       action;
    } strategy_t;

    strategy_t strategy_q[$];

    // Regret matching: clip, normalise into Q1.16, then sample by running sum
    function automatic strategy_t match_regrets(input logic [6:0] mask,
                                                input logic [6:0][31:0] regret,
                                                input logic [15:0] frac);
        strategy_t  s;
        logic [34:0] clip [7];
        logic [34:0] total;
        int          n;
        logic [19:0] run;
        logic [50:0] num;
        total = '0;
        n = 0;
        run = '0;
        s.prob = '0;
        s.action = rms_pkg::NO_ACTION;
        for (int a = 0; a < 7; a++)
        begin
            clip[a] = (mask[a] && !regret[a][31]) ? {3'b0, regret[a]} : '0;
            total += clip[a];
            if (mask[a])
                n++;
        end
        for (int a = 0; a < 7; a++)
        begin
            if (!mask[a])
                continue;
            if (total != 0)
            begin
                num = {clip[a], 16'b0};
                s.prob[a] = 17'(num / total);
            end
            else
                s.prob[a] = 17'(65536 / n);
        end
        for (int a = 0; a < 7; a++)
        begin
            if (!mask[a])
                continue;
            run += s.prob[a];
            if ({4'b0, frac} <= run)
            begin
                s.action = 3'(a);
                break;
            end
        end
        return s;
    endfunction

    // Input transfers push a prediction, output transfers pop and compare
    always @(posedge clk or negedge rst_n)
    begin
        strategy_t exp_s;
        strategy_t got;
        int        errs;
        errs = 0;
        if (!rst_n)
        begin
            fail_count <= 0;
            results_seen <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                got.prob = {prob_bet_over, prob_bet_pot, prob_bet_half, prob_bet_quarter,
                            prob_check, prob_call, prob_fold};
                got.action = chosen_action;
                if (strategy_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h", $time, got);
                    errs++;
                end
                else
                begin
                    exp_s = strategy_q.pop_front();
                    for (int a = 0; a < 7; a++)
                        if (got.prob[a] !== exp_s.prob[a])
                        begin
                            $display("%0t: prob[%0d] expected %0d actual %0d",
                                     $time, a, exp_s.prob[a], got.prob[a]);
                            errs++;
                        end
                    if (got.action !== exp_s.action)
                    begin
                        $display("%0t: chosen_action expected %0d actual %0d",
                                 $time, exp_s.action, got.action);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
                strategy_q.push_back(match_regrets(allowed_mask,
                    {regret_bet_over, regret_bet_pot, regret_bet_half, regret_bet_quarter,
                     regret_check, regret_call, regret_fold}, random_fraction));
            fail_count <= fail_count + errs;
            pending <= strategy_q.size();
        end
    end

endmodule

[tb/sv/regret_matching_sampler_tb.sv]
// Testbench top for the regret-matching sampler: stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module regret_matching_sampler_tb;

    localparam int RANDOM_ITEMS = 1500;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [6:0]  allowed_mask;
    logic [6:0][31:0] regret;
    logic [15:0] random_fraction;
    logic        out_valid;
    logic        out_stall;
    logic [6:0][16:0] prob;
    logic [2:0]  chosen_action;
    int          fail_count;
    int          pending;
    int          results_seen;
    bit          calm;

    regret_matching_sampler u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .allowed_mask(allowed_mask),
        .regret_fold(regret[0]), .regret_call(regret[1]), .regret_check(regret[2]),
        .regret_bet_quarter(regret[3]), .regret_bet_half(regret[4]),
        .regret_bet_pot(regret[5]), .regret_bet_over(regret[6]),
        .random_fraction(random_fraction), .out_valid(out_valid), .out_stall(out_stall),
        .prob_fold(prob[0]), .prob_call(prob[1]), .prob_check(prob[2]),
        .prob_bet_quarter(prob[3]), .prob_bet_half(prob[4]), .prob_bet_pot(prob[5]),
        .prob_bet_over(prob[6]), .chosen_action(chosen_action)
    );

    regret_matching_sampler_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .allowed_mask(allowed_mask),
        .regret_fold(regret[0]), .regret_call(regret[1]), .regret_check(regret[2]),
        .regret_bet_quarter(regret[3]), .regret_bet_half(regret[4]),
        .regret_bet_pot(regret[5]), .regret_bet_over(regret[6]),
        .random_fraction(random_fraction), .out_valid(out_valid), .out_stall(out_stall),
        .prob_fold(prob[0]), .prob_call(prob[1]), .prob_check(prob[2]),
        .prob_bet_quarter(prob[3]), .prob_bet_half(prob[4]), .prob_bet_pot(prob[5]),
        .prob_bet_over(prob[6]), .chosen_action(chosen_action),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls in bursts until the calm tail
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Present one item and hold it until the transfer; valid is left high when it returns
    task automatic send_strategy(input logic [6:0] mask, input logic [6:0][31:0] r,
                                 input logic [15:0] frac);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        allowed_mask <= mask;
        regret <= r;
        random_fraction <= frac;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_regret();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'($urandom_range(0, 1000));
            4: return -32'($urandom_range(1, 1000));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [6:0][31:0] r;
        int               waited;
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        allowed_mask = '0;
        regret = '0;
        random_fraction = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty and full masks, extreme regrets, zero and top fractions
        send_strategy(7'h00, {7{32'd5}}, 16'd0);
        send_strategy(7'h7f, {7{32'h7fff_ffff}}, 16'hffff);
        send_strategy(7'h7f, {7{32'h8000_0000}}, 16'hffff);
        send_strategy(7'h7f, {7{32'h0}}, 16'd0);
        send_strategy(7'h7f, {7{32'h0}}, 16'hffff);
        send_strategy(7'h7f, {32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd2}, 16'd0);
        send_strategy(7'h7f, {32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3}, 16'hffff);
        send_strategy(7'h40, {7{32'hffff_ffff}}, 16'h8000);
        send_strategy(7'h01, {7{32'd0}}, 16'hffff);
        send_strategy(7'h55, {32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1,
                              32'd7, 32'd1, 32'd9}, 16'h1234);
        send_strategy(7'h2a, {7{32'h5555_5555}}, 16'haaaa);
        send_strategy(7'h7f, {32'h0000_0001, {6{32'h8000_0000}}}, 16'h0001);
        in_valid <= 1'b0;

        // Let the pipeline drain completely before carrying on
        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 200)
                calm = 1'b1;
            for (int a = 0; a < 7; a++)
                r[a] = pick_regret();
            send_strategy(($urandom_range(0, 9) == 0) ? 7'($urandom) :
                          7'($urandom_range(1, 127)), r,
                          ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom));
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (40) @(negedge clk);
        $display("Covered %0d results: empty and full masks, clipped extremes, uniform fallback,",
                 results_seen);
        $display("truncation shortfall and zero fraction, with stalls on both channels.");
        if (fail_count == 0 && pending == 0)
            $display("[regret_matching_sampler] OK");
        else
            $display("[regret_matching_sampler] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("[regret_matching_sampler] ERROR");
        $finish;
    end

endmodule
